FILE: rtl/wphm_pkg.sv
// ----------------------------------------------------------------------------
// wphm_pkg: shared definitions for the windowed peak-hold meter
// Widths, level constants, the controller states and the fold control bundle.
// ----------------------------------------------------------------------------
package wphm_pkg;

  localparam int IDX_W       = 6;
  localparam int STORE_DEPTH = 1 << IDX_W;
  localparam int CNT_W       = IDX_W + 1;
  localparam int LEVEL_BITS  = 16;
  localparam int STAMP_W     = 32;
  localparam int WIN_W       = 16;
  localparam int ENTRY_W     = STAMP_W + LEVEL_BITS;
  localparam int OUT_W       = 3 * LEVEL_BITS + 1 + CNT_W;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [LEVEL_BITS-1:0] FULL_SCALE   = LEVEL_BITS'(1) << (LEVEL_BITS - 2);
  localparam logic [WIN_W-1:0]      WINDOW_RESET = WIN_W'(1500);

  // Register map, word addressed.
  localparam logic REG_WINDOW   = 1'b0;
  localparam logic REG_SHOW_MIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_RB,
    ST_DONE
  } wphm_state_t;

  typedef struct packed {
    logic clear;
    logic fold;
  } fold_ctl_t;

endpackage

FILE: rtl/wphm_fold.sv
// ----------------------------------------------------------------------------
// wphm_fold: rebuild accumulator
// Folds a stream of stored levels into maximum, minimum and clip state.
// ----------------------------------------------------------------------------
module wphm_fold import wphm_pkg::*; (
  input  logic                  clk,
  input  fold_ctl_t             ctl,
  input  logic [LEVEL_BITS-1:0] level,
  output logic [LEVEL_BITS-1:0] max_level,
  output logic [LEVEL_BITS-1:0] min_level,
  output logic                  clip
);

  logic [LEVEL_BITS-1:0] max_r;
  logic [LEVEL_BITS-1:0] min_r;
  logic                  clip_r;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      max_r  <= '0;
      min_r  <= FULL_SCALE;
      clip_r <= 1'b0;
    end else if (ctl.fold) begin
      if (level > max_r) max_r <= level;
      if (level < min_r) min_r <= level;
      if (level > FULL_SCALE) clip_r <= 1'b1;
    end
  end

  assign max_level = max_r;
  assign min_level = min_r;
  assign clip      = clip_r;

endmodule

FILE: rtl/windowed_peak_hold_meter.sv
// ----------------------------------------------------------------------------
// windowed_peak_hold_meter: sliding-window peak-hold level meter
// Stores level samples with their tick time, expires old ones and rebuilds
// the held maximum, minimum and clip flag from the samples that remain.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries in_tuser (0 level sample, 1 one
// millisecond tick) and in_tdata (the Q2.14 level); each one produces exactly
// one result transfer with the current level, held maximum and minimum, clip
// flag and store occupancy. Samples and stamps share one 64-entry memory.
// Steps from input transfer to result: the oldest entry is read and checked,
// each expired entry is dropped and the next oldest checked, the rebuild walk
// reads and folds the remaining entries if anything was dropped, and the
// output register is loaded; an emptied store ends the check and the walk
// without a read. The next input is taken once the controller is back in
// idle; the longest case is a full store that expires. One item is processed
// at a time. A stalled receiver holds the result in the output register and
// the next item's result in the controller, after which the input stalls.
// Configuration is to be written over APB only while idle; nothing enforces it.
// Reset clears counters, time, held values and both channels, not the memory.
// ----------------------------------------------------------------------------
module windowed_peak_hold_meter import wphm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [LEVEL_BITS-1:0]  in_tdata,    // [15:0] level
  input  logic                   in_tuser,    // [0] mode
  // Result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] current_level, [31:16] peak_max, [47:32] peak_min,
  // [48] clip_seen, [55:49] entries_held
  output logic [OUT_BYTES_W-1:0] out_tdata,
  // Configuration port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  // Configuration registers
  logic [WIN_W-1:0] window_r;
  logic             show_min_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WINDOW_RESET;
      show_min_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_WINDOW:   window_r   <= cfg_pwdata[WIN_W-1:0];
        REG_SHOW_MIN: show_min_r <= cfg_pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_WINDOW:   cfg_prdata = {{(32-WIN_W){1'b0}}, window_r};
      REG_SHOW_MIN: cfg_prdata = {31'b0, show_min_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // Controller state
  wphm_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]      oldest_r, oldest_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [STAMP_W-1:0]    time_r, time_nxt;
  logic [LEVEL_BITS-1:0] max_r, max_nxt;
  logic [LEVEL_BITS-1:0] min_r, min_nxt;
  logic                  clip_r, clip_nxt;
  logic [LEVEL_BITS-1:0] last_r, last_nxt;
  logic                  dropped_r, dropped_nxt;
  logic [IDX_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      rd_left_r, rd_left_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  // Entry memory: {stamp, level}
  logic [ENTRY_W-1:0]    mem [STORE_DEPTH];
  logic [ENTRY_W-1:0]    rd_data_r;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic [ENTRY_W-1:0]    wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rd_data_r <= mem[rd_addr];
  end

  logic [LEVEL_BITS-1:0] rd_level;
  logic [STAMP_W-1:0]    rd_stamp;
  logic [STAMP_W-1:0]    age;
  logic                  expired;
  logic                  in_xfer;
  logic                  out_free;
  logic                  rb_done;

  assign rd_level = rd_data_r[LEVEL_BITS-1:0];
  assign rd_stamp = rd_data_r[ENTRY_W-1:LEVEL_BITS];
  assign age      = time_r - rd_stamp;
  assign expired  = age > {{(STAMP_W-WIN_W){1'b0}}, window_r};
  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign rb_done  = (rd_left_r == '0) && !rd_vld_r;

  // Rebuild accumulator
  fold_ctl_t             fold_ctl;
  logic [LEVEL_BITS-1:0] fold_max, fold_min;
  logic                  fold_clip;

  wphm_fold u_fold (
    .clk       (clk),
    .ctl       (fold_ctl),
    .level     (rd_level),
    .max_level (fold_max),
    .min_level (fold_min),
    .clip      (fold_clip)
  );

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    time_nxt      = time_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    clip_nxt      = clip_r;
    last_nxt      = last_r;
    dropped_nxt   = dropped_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_left_nxt   = rd_left_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    wr_addr       = oldest_r + count_r[IDX_W-1:0];
    wr_data       = {time_r, in_tdata};
    rd_addr       = oldest_r;
    fold_ctl      = '0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_xfer) begin
          dropped_nxt = 1'b0;
          state_nxt   = ST_EXP_RD;
          if (!in_tuser) begin
            last_nxt = in_tdata;
            if (in_tdata > FULL_SCALE) clip_nxt = 1'b1;
            if (in_tdata >= max_r) max_nxt = in_tdata;
            if (show_min_r && in_tdata <= min_r) min_nxt = in_tdata;
            // A full store drops its oldest entry and the new sample takes
            // that slot; the wrapped write address is the same either way.
            mem_we = 1'b1;
            if (count_r == CNT_W'(STORE_DEPTH)) begin
              oldest_nxt  = oldest_r + 1'b1;
              dropped_nxt = 1'b1;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end else begin
            time_nxt = time_r + 1'b1;
          end
        end
      end
      ST_EXP_RD: begin
        if (count_r != '0) begin
          mem_re    = 1'b1;
          state_nxt = ST_EXP_CHK;
        end else if (dropped_r) begin
          fold_ctl.clear = 1'b1;
          rd_left_nxt    = '0;
          state_nxt      = ST_RB;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_EXP_CHK: begin
        if (expired) begin
          oldest_nxt  = oldest_r + 1'b1;
          count_nxt   = count_r - 1'b1;
          dropped_nxt = 1'b1;
          state_nxt   = ST_EXP_RD;
        end else if (dropped_r) begin
          fold_ctl.clear = 1'b1;
          rd_ptr_nxt     = oldest_r;
          rd_left_nxt    = count_r;
          state_nxt      = ST_RB;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RB: begin
        // Reads are issued back to back; each level is folded in the cycle after its read.
        fold_ctl.fold = rd_vld_r;
        rd_addr       = rd_ptr_r;
        if (rd_left_r != '0) begin
          mem_re      = 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_ptr_nxt  = rd_ptr_r + 1'b1;
          rd_left_nxt = rd_left_r - 1'b1;
        end
        if (rb_done) begin
          max_nxt   = fold_max;
          min_nxt   = fold_min;
          clip_nxt  = fold_clip;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {count_r, clip_r, min_r, max_r, last_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      time_r      <= '0;
      max_r       <= '0;
      min_r       <= '0;
      clip_r      <= 1'b0;
      last_r      <= '0;
      dropped_r   <= 1'b0;
      rd_left_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      time_r      <= time_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      clip_r      <= clip_nxt;
      last_r      <= last_nxt;
      dropped_r   <= dropped_nxt;
      rd_left_r   <= rd_left_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_BYTES_W'(out_data_r);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STORE_DEPTH))
    else $error("store occupancy above depth");

  a_chk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXP_CHK |-> count_r != '0)
    else $error("expiry check on an empty store");

  a_fold_in_rb: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r == ST_RB)
    else $error("rebuild read data outside the rebuild walk");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside the done state");
`endif

endmodule
